### hdl/i2cbs_pkg.sv
// ----------------------------------------------------------------------------
// i2cbs_pkg
// Shared types and constants for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbs_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int PHASE_W     = 16;
    localparam int STEP_W      = 5;
    // index of the closing step of send byte and read byte
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * BYTE_BITS + 1);
    localparam logic [PHASE_W-1:0] PHASE_RESET = PHASE_W'(1);

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_SEND  = 3'd3,
        OP_READ  = 3'd4,
        OP_ACK   = 3'd5,
        OP_NACK  = 3'd6,
        OP_RACK  = 3'd7
    } op_t;

    typedef struct packed {
        logic [PHASE_W-1:0]   phase_count;
        logic [STEP_W-1:0]    step_index;
        op_t                  active_op;
        logic [BYTE_BITS-1:0] shift;
        logic                 scl;
        logic                 sda;
        logic                 drv;
        logic                 ack;
        logic [BYTE_BITS-1:0] rx_last;
    } seq_state_t;

    localparam seq_state_t STATE_RESET = '{
        phase_count: '0,
        step_index:  '0,
        active_op:   OP_NONE,
        shift:       '0,
        scl:         1'b1,
        sda:         1'b1,
        drv:         1'b1,
        ack:         1'b1,
        rx_last:     '0
    };

endpackage

`default_nettype wire

### hdl/i2c_master_bit_sequencer.sv
// A result beat is registered and appears in the cycle after its tick is accepted.
// Throughput: one tick per cycle while results are taken; the step logic feeds
// the sequencer state register, which also holds the result, and a held result
// does not stop the next tick as long as the result side takes it in the same cycle.
// Reset (aresetn low, synchronous): idle, SCL and SDA high and driven,
// ack 1, rx byte 0, phase length 1, no result pending.
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master pin sequencer: one input beat per base tick, one result beat
// with the pin levels, status and received data per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer (
    input  var logic        aclk,
    input  var logic        aresetn,

    input  var logic        cfg_valid,
    output logic            cfg_ready,
    input  var logic [15:0] cfg_data,

    input  var logic        s_valid,
    output logic            s_ready,
    input  var logic [2:0]  s_op,
    input  var logic [7:0]  s_tx_byte,
    input  var logic        s_sda_in,

    output logic            m_valid,
    input  var logic        m_ready,
    output logic            m_scl_level,
    output logic            m_sda_level,
    output logic            m_sda_drive,
    output logic            m_busy_res,
    output logic            m_done_res,
    output logic [7:0]      m_rx_byte,
    output logic            m_ack_seen
);

    i2cbs_pkg::seq_state_t            state_reg;
    i2cbs_pkg::seq_state_t            state_next;
    logic [i2cbs_pkg::PHASE_W-1:0]    phase_ticks_reg;
    logic [i2cbs_pkg::PHASE_W-1:0]    ticks;
    logic                             done_reg;
    logic                             done_next;
    logic                             m_valid_reg;
    logic                             in_beat;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_beat   = s_valid && s_ready;

    // a zero phase length behaves as one tick
    assign ticks = (phase_ticks_reg == '0) ? i2cbs_pkg::PHASE_RESET : phase_ticks_reg;

    i2cbs_step u_step (
        .cur     (state_reg),
        .op      (i2cbs_pkg::op_t'(s_op)),
        .tx_byte (s_tx_byte),
        .sda_in  (s_sda_in),
        .ticks   (ticks),
        .nxt     (state_next),
        .done    (done_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= i2cbs_pkg::PHASE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            phase_ticks_reg <= cfg_data;
        end
    end

    // the state register doubles as the result payload: it only moves on a
    // beat, and a beat only happens once the previous result has gone
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= i2cbs_pkg::STATE_RESET;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_beat) begin
                state_reg <= state_next;
                done_reg  <= done_next;
            end
            if (in_beat) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_scl_level = state_reg.scl;
    assign m_sda_level = state_reg.sda;
    assign m_sda_drive = state_reg.drv;
    assign m_busy_res  = (state_reg.active_op != i2cbs_pkg::OP_NONE);
    assign m_done_res  = done_reg;
    assign m_rx_byte   = state_reg.rx_last;
    assign m_ack_seen  = state_reg.ack;

endmodule

`default_nettype wire

### hdl/i2cbs_step.sv
// ----------------------------------------------------------------------------
// i2cbs_step
// One base tick of the sequencer: phase countdown, command take-up and the
// pin actions of the current step.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbs_step (
    input  var i2cbs_pkg::seq_state_t                 cur,
    input  var i2cbs_pkg::op_t                        op,
    input  var logic [i2cbs_pkg::BYTE_BITS-1:0]       tx_byte,
    input  var logic                                  sda_in,
    input  var logic [i2cbs_pkg::PHASE_W-1:0]         ticks,
    output i2cbs_pkg::seq_state_t                     nxt,
    output logic                                      done
);

    always_comb begin
        logic                          act;
        logic                          fin;
        logic [i2cbs_pkg::STEP_W-1:0]  k;
        logic [i2cbs_pkg::BYTE_BITS-1:0] shifted;

        nxt  = cur;
        act  = 1'b0;
        fin  = 1'b0;
        done = 1'b0;

        if (cur.active_op == i2cbs_pkg::OP_NONE) begin
            if (op != i2cbs_pkg::OP_NONE) begin
                nxt.active_op  = op;
                nxt.step_index = '0;
                if (op == i2cbs_pkg::OP_SEND) begin
                    nxt.shift = tx_byte;
                end
                act = 1'b1;
            end
        end else begin
            nxt.phase_count = cur.phase_count - 1'b1;
            if (nxt.phase_count == '0) begin
                nxt.step_index = cur.step_index + 1'b1;
                act = 1'b1;
            end
        end

        k       = nxt.step_index;
        shifted = {nxt.shift[i2cbs_pkg::BYTE_BITS-2:0], 1'b0};

        if (act) begin
            case (nxt.active_op)
                i2cbs_pkg::OP_START: begin
                    if (k == 5'd0) begin
                        nxt.drv = 1'b1;
                        nxt.scl = 1'b1;
                        nxt.sda = 1'b1;
                    end else if (k == 5'd1) begin
                        nxt.sda = 1'b0;
                    end else if (k == 5'd2) begin
                        nxt.scl = 1'b0;
                    end else begin
                        nxt.sda = 1'b1;
                        fin     = 1'b1;
                    end
                end
                i2cbs_pkg::OP_STOP: begin
                    if (k == 5'd0) begin
                        nxt.drv = 1'b1;
                        nxt.sda = 1'b0;
                    end else if (k == 5'd1) begin
                        nxt.scl = 1'b1;
                    end else if (k == 5'd2) begin
                        nxt.sda = 1'b1;
                    end else begin
                        fin = 1'b1;
                    end
                end
                i2cbs_pkg::OP_ACK, i2cbs_pkg::OP_NACK: begin
                    if (k == 5'd0) begin
                        nxt.drv = 1'b1;
                        nxt.scl = 1'b0;
                        nxt.sda = (nxt.active_op == i2cbs_pkg::OP_NACK);
                    end else if (k == 5'd1) begin
                        nxt.scl = 1'b1;
                    end else begin
                        nxt.scl = 1'b0;
                        fin     = 1'b1;
                    end
                end
                i2cbs_pkg::OP_RACK: begin
                    if (k == 5'd0) begin
                        nxt.drv = 1'b0;
                    end else if (k == 5'd1) begin
                        nxt.scl = 1'b1;
                    end else if (k == 5'd2) begin
                        nxt.ack = sda_in;
                        nxt.scl = 1'b0;
                    end else begin
                        fin = 1'b1;
                    end
                end
                i2cbs_pkg::OP_SEND: begin
                    if (k == 5'd0) begin
                        nxt.drv = 1'b1;
                    end else if (k >= i2cbs_pkg::LAST_STEP) begin
                        nxt.scl = 1'b0;
                        fin     = 1'b1;
                    end else if (k[0]) begin
                        // later bits: drop SCL and advance to the next data bit
                        if (k > 5'd1) begin
                            nxt.scl   = 1'b0;
                            nxt.shift = shifted;
                        end
                        nxt.sda = nxt.shift[i2cbs_pkg::BYTE_BITS-1];
                    end else begin
                        nxt.scl = 1'b1;
                    end
                end
                i2cbs_pkg::OP_READ: begin
                    if (k == 5'd0) begin
                        nxt.drv   = 1'b0;
                        nxt.shift = '0;
                    end else if (k >= i2cbs_pkg::LAST_STEP) begin
                        nxt.rx_last = nxt.shift;
                        fin         = 1'b1;
                    end else if (k[0]) begin
                        nxt.scl = 1'b1;
                    end else begin
                        nxt.shift = {nxt.shift[i2cbs_pkg::BYTE_BITS-2:0], sda_in};
                        nxt.scl   = 1'b0;
                    end
                end
                default: begin
                    fin = 1'b1;
                end
            endcase

            if (fin) begin
                nxt.active_op   = i2cbs_pkg::OP_NONE;
                nxt.step_index  = '0;
                nxt.phase_count = '0;
                done            = 1'b1;
            end else begin
                nxt.phase_count = ticks;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/i2cbs_checker.sv
// ----------------------------------------------------------------------------
// i2cbs_checker
// Port-level checks for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbs_checker (
    input var logic       aclk,
    input var logic       aresetn,
    input var logic       s_valid,
    input var logic       s_ready,
    input var logic       m_valid,
    input var logic       m_ready,
    input var logic       m_scl_level,
    input var logic       m_sda_level,
    input var logic       m_sda_drive,
    input var logic       m_busy_res,
    input var logic       m_done_res,
    input var logic [7:0] m_rx_byte,
    input var logic       m_ack_seen
);

    // a completing beat never reports the sequence as still running
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done beat shows busy");

    // a taken result always frees the input side
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while results are taken");

    // every accepted tick yields a result beat on the next cycle
    a_beat_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted tick produced no result");

    // reset drops any pending result
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_scl_level)
            && $stable(m_sda_level) && $stable(m_sda_drive)
            && $stable(m_busy_res) && $stable(m_done_res)
            && $stable(m_rx_byte) && $stable(m_ack_seen))
        else $error("stalled result changed");

endmodule

bind i2c_master_bit_sequencer i2cbs_checker u_i2cbs_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_scl_level (m_scl_level),
    .m_sda_level (m_sda_level),
    .m_sda_drive (m_sda_drive),
    .m_busy_res  (m_busy_res),
    .m_done_res  (m_done_res),
    .m_rx_byte   (m_rx_byte),
    .m_ack_seen  (m_ack_seen)
);

`default_nettype wire
